// File: rtl/nmea_line_checksum_classifier_macros.svh
// -----------------------------------------------------------------------------
// NMEA line checksum classifier: assertion macros
// Shared concurrent assertion forms for the classifier RTL.
// -----------------------------------------------------------------------------
`ifndef NMEA_LINE_CHECKSUM_CLASSIFIER_MACROS_SVH
`define NMEA_LINE_CHECKSUM_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NLCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nlcc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NLCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nlcc assertion failed");

`endif

// File: rtl/nlcc_pkg.sv
// -----------------------------------------------------------------------------
// NMEA line checksum classifier package
// Beat types, character codes, sentence kinds and small decode helpers.
// -----------------------------------------------------------------------------
`default_nettype none

package nlcc_pkg;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_STAR = 8'h2A;

  localparam int unsigned MIN_LINE = 6;
  localparam int unsigned PFX_LEN  = 6;
  localparam int unsigned PFX_W    = PFX_LEN * 8;

  localparam logic [PFX_W-1:0] PFX_GNRMC = "$GNRMC";
  localparam logic [PFX_W-1:0] PFX_GPRMC = "$GPRMC";
  localparam logic [PFX_W-1:0] PFX_GPGSV = "$GPGSV";
  localparam logic [PFX_W-1:0] PFX_GLGSV = "$GLGSV";
  localparam logic [PFX_W-1:0] PFX_GAGSV = "$GAGSV";
  localparam logic [PFX_W-1:0] PFX_BDGSV = "$BDGSV";
  localparam logic [PFX_W-1:0] PFX_GNGGA = "$GNGGA";
  localparam logic [PFX_W-1:0] PFX_GPGGA = "$GPGGA";

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_RMC   = 2'd1,
    KIND_GSV   = 2'd2,
    KIND_GGA   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_in_buffer;
  } in_item_t;

  typedef struct packed {
    logic       checksum_ok;
    logic       has_star;
    logic [1:0] sentence_kind;
    logic [7:0] line_length;
    logic [7:0] computed_checksum;
    logic [7:0] received_checksum;
  } out_item_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  function automatic hex_digit_t hex_digit(input logic [7:0] b);
    hex_digit_t d;
    d.ok  = 1'b0;
    d.val = b[3:0];
    if (b >= "0" && b <= "9") begin
      d.ok = 1'b1;
    end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
      d.ok  = 1'b1;
      d.val = b[3:0] + 4'd9;
    end
    return d;
  endfunction

  function automatic kind_t classify(input logic [PFX_W-1:0] pfx);
    kind_t k;
    case (pfx)
      PFX_GNRMC, PFX_GPRMC:                       k = KIND_RMC;
      PFX_GPGSV, PFX_GLGSV, PFX_GAGSV, PFX_BDGSV: k = KIND_GSV;
      PFX_GNGGA, PFX_GPGGA:                       k = KIND_GGA;
      default:                                    k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// File: rtl/nlcc_in_if.sv
// -----------------------------------------------------------------------------
// NMEA line checksum classifier: input channel
// Valid/ready channel carrying one received character per beat.
// -----------------------------------------------------------------------------
`default_nettype none

interface nlcc_in_if;
  import nlcc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/nlcc_out_if.sv
// -----------------------------------------------------------------------------
// NMEA line checksum classifier: result channel
// Valid/ready channel carrying one line summary per beat.
// -----------------------------------------------------------------------------
`default_nettype none

interface nlcc_out_if;
  import nlcc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/nmea_line_checksum_classifier.sv
// -----------------------------------------------------------------------------
// NMEA line checksum classifier
// Splits a character stream into lines and reports checksum and sentence kind.
// -----------------------------------------------------------------------------
// Takes one character per beat and sustains one beat per cycle unless the result
// register stalls. A beat lands in an input register, then the line tracker
// (XOR, star, hex and prefix registers) folds it in; a closing line loads the
// result register in that same cycle. The only stall source is the result
// register: while a summary waits to be taken, the input register holds and
// in_ch.ready drops once both stages are full. Lines of fewer than six
// characters and runs of CR/LF produce no beat.
`default_nettype none

`include "nmea_line_checksum_classifier_macros.svh"

module nmea_line_checksum_classifier (
  input wire logic clk,
  input wire logic rst_n,
  nlcc_in_if.sink   in_ch,
  nlcc_out_if.source out_ch
);
  import nlcc_pkg::*;

  // Input stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // Line tracker
  logic [7:0]       xor_r,   xor_nxt;
  logic [7:0]       xstar_r, xstar_nxt;
  logic             star_r,  star_nxt;
  logic [7:0]       hex_r,   hex_nxt;
  logic             hopen_r, hopen_nxt;
  logic [7:0]       count_r, count_nxt;
  logic [PFX_W-1:0] pfx_r,   pfx_nxt;

  // Result stage
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r,  out_data_nxt;

  logic       s1_adv;
  logic       s1_fire;
  logic       is_term;
  logic       closing;
  logic       emit;
  hex_digit_t hd;

  // Values after folding in a non-terminator character
  logic [7:0]       u_xor, u_xstar, u_hex, u_count;
  logic             u_star, u_hopen;
  logic [PFX_W-1:0] u_pfx;

  // State the closed line is reported from
  logic [7:0]       c_xor_star, c_hex, c_count;
  logic             c_star;
  logic [PFX_W-1:0] c_pfx;

  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && s1_adv;
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_comb begin
    hd      = hex_digit(s1_byte_r);
    is_term = (s1_byte_r == CHAR_CR) || (s1_byte_r == CHAR_LF);

    u_pfx   = (count_r < 8'(MIN_LINE)) ? {pfx_r[PFX_W-9:0], s1_byte_r} : pfx_r;
    u_xstar = xstar_r;
    u_star  = star_r;
    u_hex   = hex_r;
    u_hopen = hopen_r;
    if (s1_byte_r == CHAR_STAR) begin
      u_xstar = xor_r;
      u_star  = 1'b1;
      u_hex   = '0;
      u_hopen = 1'b1;
    end else if (hopen_r) begin
      if (hd.ok) begin
        u_hex = {hex_r[3:0], hd.val};
      end else begin
        u_hopen = 1'b0;
      end
    end
    // first character of a line stays out of the XOR
    u_xor   = (count_r != '0) ? (xor_r ^ s1_byte_r) : xor_r;
    u_count = (count_r != 8'hFF) ? (count_r + 8'd1) : count_r;

    closing = is_term || s1_last_r;

    if (is_term) begin
      c_xor_star = xstar_r;
      c_hex      = hex_r;
      c_count    = count_r;
      c_star     = star_r;
      c_pfx      = pfx_r;
    end else begin
      c_xor_star = u_xstar;
      c_hex      = u_hex;
      c_count    = u_count;
      c_star     = u_star;
      c_pfx      = u_pfx;
    end

    emit = closing && (c_count >= 8'(MIN_LINE));

    out_data_nxt.checksum_ok       = c_star && (c_xor_star == c_hex);
    out_data_nxt.has_star          = c_star;
    out_data_nxt.sentence_kind     = classify(c_pfx);
    out_data_nxt.line_length       = c_count;
    out_data_nxt.computed_checksum = c_star ? c_xor_star : 8'h00;
    out_data_nxt.received_checksum = c_star ? c_hex : 8'h00;

    if (closing) begin
      xor_nxt   = '0;
      xstar_nxt = '0;
      star_nxt  = 1'b0;
      hex_nxt   = '0;
      hopen_nxt = 1'b0;
      count_nxt = '0;
      pfx_nxt   = '0;
    end else begin
      xor_nxt   = u_xor;
      xstar_nxt = u_xstar;
      star_nxt  = u_star;
      hex_nxt   = u_hex;
      hopen_nxt = u_hopen;
      count_nxt = u_count;
      pfx_nxt   = u_pfx;
    end

    // drop the result once taken; load a new one when the input stage fires on a line that emits
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (s1_fire) begin
      out_valid_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      xor_r       <= '0;
      xstar_r     <= '0;
      star_r      <= 1'b0;
      hex_r       <= '0;
      hopen_r     <= 1'b0;
      count_r     <= '0;
      pfx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_fire) begin
        xor_r   <= xor_nxt;
        xstar_r <= xstar_nxt;
        star_r  <= star_nxt;
        hex_r   <= hex_nxt;
        hopen_r <= hopen_nxt;
        count_r <= count_nxt;
        pfx_r   <= pfx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.data.rx_byte;
      s1_last_r <= in_ch.data.last_in_buffer;
    end
    if (s1_fire && emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  `NLCC_ASSERT_NOW(a_len_min, clk, rst_n, out_valid_r,
    out_data_r.line_length >= 8'(MIN_LINE))
  `NLCC_ASSERT_NOW(a_ok_needs_star, clk, rst_n, out_valid_r && !out_data_r.has_star,
    !out_data_r.checksum_ok && out_data_r.computed_checksum == 8'h00 &&
    out_data_r.received_checksum == 8'h00)
  `NLCC_ASSERT_NEXT(a_close_clears, clk, rst_n, s1_fire && closing,
    count_r == 8'h00 && !star_r && !hopen_r)
  `NLCC_ASSERT_NEXT(a_count_sat, clk, rst_n, s1_fire && !closing && count_r == 8'hFF,
    count_r == 8'hFF)
  `NLCC_ASSERT_NEXT(a_no_fire_hold, clk, rst_n, !s1_fire,
    $stable(count_r) && $stable(xor_r) && $stable(pfx_r))

endmodule

`default_nettype wire
